// File: rtl/thv_pkg.sv
// ============================================================================
// thv_pkg
// Shared types, constants and helpers of the texture header validator.
// ============================================================================
package thv_pkg;

    localparam int HEADER_BYTES = 28;
    localparam int SIZE_SLOTS   = 4;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int QUEUE_DEPTH  = 2;

    localparam int SLOT_BASE      = 12;
    localparam int PICMIP_LAST    = 3;
    localparam int PICMIP_MIN_DIM = 32;
    localparam int DIM_LIMIT      = 32767;
    localparam int PIX_BYTES      = 4;

    localparam logic [7:0]  TAG_0           = 8'h49;
    localparam logic [7:0]  TAG_1           = 8'h57;
    localparam logic [7:0]  TAG_2           = 8'h69;
    localparam logic [7:0]  FMT_LOW         = 8'd1;
    localparam logic [7:0]  FMT_HIGH        = 8'd13;
    localparam logic [7:0]  FLAG_NO_PICMIP  = 8'h01;
    localparam logic [7:0]  FLAG_NO_MIPMAPS = 8'h02;
    localparam logic [31:0] SIZE_LIMIT      = 32'h7FFF_FFFF;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd6;
    localparam logic        RST_DECODE_MODE      = 1'b0;
    localparam logic [3:0]  RST_ARGB_FORMAT_CODE = 4'd1;
    localparam logic [30:0] RST_MAX_MEMBER_BYTES = 31'd67108864;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARGB_FORMAT_CODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MEMBER_BYTES = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TRUNCATED  = 4'd1;
    localparam logic [3:0] ST_TAG        = 4'd2;
    localparam logic [3:0] ST_VERSION    = 4'd3;
    localparam logic [3:0] ST_FORMAT     = 4'd4;
    localparam logic [3:0] ST_DIMS       = 4'd5;
    localparam logic [3:0] ST_FILESIZE   = 4'd6;
    localparam logic [3:0] ST_DEC_FORMAT = 4'd7;
    localparam logic [3:0] ST_DEC_FLAGS  = 4'd8;
    localparam logic [3:0] ST_DEC_DIMS   = 4'd9;
    localparam logic [3:0] ST_LAYOUT     = 4'd10;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd11;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic        decode_mode;
        logic [3:0]  argb_format_code;
        logic [30:0] max_member_bytes;
    } thv_cfg_t;

    typedef struct packed {
        logic                        has_pixel;
        logic [31:0]                 pixel;
        logic                        has_status;
        logic [31:0]                 count;
        logic                        tag_ok;
        logic [7:0]                  version;
        logic [7:0]                  format;
        logic [7:0]                  flags;
        logic [15:0]                 width;
        logic [15:0]                 height;
        logic [15:0]                 depth;
        logic [SIZE_SLOTS-1:0][31:0] slot;
    } thv_entry_t;

    function automatic logic [4:0] bit_length16(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/thv_front.sv
// ============================================================================
// thv_front
// Takes file bytes, counts them, captures the header and pixel bytes and
// posts pixel and end-of-file events to the queue.
// ============================================================================
module thv_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  thv_pkg::thv_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output thv_pkg::thv_entry_t  push_entry
);

    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [7:0]  header_reg [thv_pkg::HEADER_BYTES];
    logic [7:0]  group_reg [3];
    logic [7:0]  view [thv_pkg::HEADER_BYTES];

    logic        accept;
    logic        in_header;
    logic        in_payload;
    logic        pix_event;
    logic [31:0] count_inc;

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign in_header  = count_reg < 32'(thv_pkg::HEADER_BYTES);
    assign in_payload = !in_header && (count_reg != thv_pkg::COUNT_MAX);
    assign pix_event  = in_payload && (count_reg[1:0] == 2'd3) && cfg.decode_mode;
    assign count_inc  = (count_reg == thv_pkg::COUNT_MAX) ? count_reg : count_reg + 32'd1;
    assign push_valid = in_valid && (pix_event || last_byte);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = last_byte ? 32'd0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 32'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_header)
        begin
            header_reg[count_reg[thv_pkg::HDR_IDX_W-1:0]] <= data_byte;
        end
        if (accept && in_payload && (count_reg[1:0] != 2'd3))
        begin
            group_reg[count_reg[1:0]] <= data_byte;
        end
    end

    // header as it stands once the current byte is in
    always_comb
    begin
        for (int i = 0; i < thv_pkg::HEADER_BYTES; i++)
        begin
            view[i] = (in_header && (count_reg[thv_pkg::HDR_IDX_W-1:0] == thv_pkg::HDR_IDX_W'(i)))
                      ? data_byte : header_reg[i];
        end
    end

    always_comb
    begin
        push_entry            = '0;
        push_entry.has_pixel  = pix_event;
        push_entry.pixel      = {data_byte, group_reg[0], group_reg[1], group_reg[2]};
        push_entry.has_status = last_byte;
        push_entry.count      = count_inc;
        push_entry.tag_ok     = (view[0] == thv_pkg::TAG_0) && (view[1] == thv_pkg::TAG_1)
                                && (view[2] == thv_pkg::TAG_2);
        push_entry.version    = view[3];
        push_entry.format     = view[4];
        push_entry.flags      = view[5];
        push_entry.width      = {view[7], view[6]};
        push_entry.height     = {view[9], view[8]};
        push_entry.depth      = {view[11], view[10]};
        for (int i = 0; i < thv_pkg::SIZE_SLOTS; i++)
        begin
            push_entry.slot[i] = {view[thv_pkg::SLOT_BASE + 4 * i + 3],
                                  view[thv_pkg::SLOT_BASE + 4 * i + 2],
                                  view[thv_pkg::SLOT_BASE + 4 * i + 1],
                                  view[thv_pkg::SLOT_BASE + 4 * i]};
        end
    end

endmodule

// File: rtl/thv_queue.sv
// ============================================================================
// thv_queue
// Short event queue between the byte front end and the check back end.
// ============================================================================
module thv_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  thv_pkg::thv_entry_t  push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output thv_pkg::thv_entry_t  pop_entry
);

    localparam int PTR_W = $clog2(thv_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(thv_pkg::QUEUE_DEPTH + 1);

    thv_pkg::thv_entry_t slot_reg [thv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = fill_reg != CNT_W'(thv_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(thv_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(thv_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/thv_back.sv
// ============================================================================
// thv_back
// Runs the header checks on end-of-file events and drives result
// transactions through a two-stage pipeline with an output register.
// ============================================================================
module thv_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  thv_pkg::thv_cfg_t    cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  thv_pkg::thv_entry_t  pop_entry,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [31:0]          pixel_rgba,
    output logic [3:0]           status,
    output logic [7:0]           version,
    output logic [7:0]           format,
    output logic [7:0]           flags,
    output logic [15:0]          width,
    output logic [15:0]          height,
    output logic [15:0]          depth,
    output logic [4:0]           mip_count,
    output logic                 last_result
);

    typedef struct packed {
        logic        kind;
        logic [31:0] pixel;
        logic        trunc;
        logic        tag_bad;
        logic        ver_bad;
        logic        fmt_bad;
        logic        dims_bad;
        logic        size_bad;
        logic        dec;
        logic        dfmt_bad;
        logic        dflag_bad;
        logic        ddim_bad;
        logic        n_big;
        logic [31:0] count;
        logic [31:0] area;
        logic [7:0]  version;
        logic [7:0]  format;
        logic [7:0]  flags;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] depth;
        logic [4:0]  mips;
    } thv_chk_t;

    thv_pkg::thv_entry_t e;
    thv_chk_t            s1_reg;
    thv_chk_t            s1_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                pix_done_reg;
    logic                pix_done_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                kind_reg;
    logic [31:0]         pixel_reg;
    logic [3:0]          status_reg;
    logic [7:0]          version_reg;
    logic [7:0]          format_reg;
    logic [7:0]          flags_reg;
    logic [15:0]         width_reg;
    logic [15:0]         height_reg;
    logic [15:0]         depth_reg;
    logic [4:0]          mips_reg;
    logic [3:0]          status_next;

    logic                out_load;
    logic                s1_free;
    logic                take;
    logic                pix_phase;
    logic [15:0]         max_dim;
    logic [4:0]          mips;
    logic                disabled;
    logic                slot_bad;
    logic [33:0]         expect_bytes;
    logic                too_large;
    logic                layout_bad;

    assign e         = pop_entry;
    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free   = !s1_valid_reg || out_load;
    assign take      = s1_free && pop_valid;
    assign pix_phase = e.has_pixel && !pix_done_reg;
    assign pop_ready = s1_free && !(pix_phase && e.has_status);

    // stage one: independent checks and the area product
    always_comb
    begin
        max_dim = e.width;
        if (e.height > max_dim)
        begin
            max_dim = e.height;
        end
        if (e.depth > max_dim)
        begin
            max_dim = e.depth;
        end
        if ((e.flags & thv_pkg::FLAG_NO_MIPMAPS) != 8'd0 || max_dim == 16'd0)
        begin
            mips = 5'd1;
        end
        else
        begin
            mips = 5'd1 + thv_pkg::bit_length16(max_dim - 16'd1);
        end

        disabled = ((e.flags & (thv_pkg::FLAG_NO_PICMIP | thv_pkg::FLAG_NO_MIPMAPS)) != 8'd0)
                   || (e.width < 16'(thv_pkg::PICMIP_MIN_DIM))
                   || (e.height < 16'(thv_pkg::PICMIP_MIN_DIM));
        slot_bad = 1'b0;
        for (int i = 0; i < thv_pkg::SIZE_SLOTS; i++)
        begin
            if (((i == 0 || (!disabled && i <= thv_pkg::PICMIP_LAST)) && e.slot[i] == 32'd0)
                || (e.slot[i] != 32'd0 && (e.slot[i] <= 32'(thv_pkg::HEADER_BYTES)
                                           || e.slot[i] > e.count)))
            begin
                slot_bad = 1'b1;
            end
            if (i != 0 && e.slot[i] > e.slot[(i == 0) ? 0 : i - 1])
            begin
                slot_bad = 1'b1;
            end
        end

        s1_next           = s1_reg;
        s1_next.kind      = !pix_phase;
        s1_next.pixel     = e.pixel;
        s1_next.trunc     = e.count < 32'(thv_pkg::HEADER_BYTES);
        s1_next.tag_bad   = !e.tag_ok;
        s1_next.ver_bad   = e.version != cfg.expected_version;
        s1_next.fmt_bad   = (e.format < thv_pkg::FMT_LOW) || (e.format > thv_pkg::FMT_HIGH);
        s1_next.dims_bad  = (e.width == 16'd0) || (e.height == 16'd0) || (e.depth == 16'd0)
                            || (e.width > 16'(thv_pkg::DIM_LIMIT))
                            || (e.height > 16'(thv_pkg::DIM_LIMIT))
                            || (e.depth > 16'(thv_pkg::DIM_LIMIT));
        s1_next.size_bad  = (e.count > thv_pkg::SIZE_LIMIT) || (e.slot[0] != e.count) || slot_bad;
        s1_next.dec       = cfg.decode_mode;
        s1_next.dfmt_bad  = e.format != {4'd0, cfg.argb_format_code};
        s1_next.dflag_bad = e.flags != thv_pkg::FLAG_NO_MIPMAPS;
        s1_next.ddim_bad  = (e.depth != 16'd1) || (mips != 5'd1);
        s1_next.n_big     = e.count > {1'b0, cfg.max_member_bytes};
        s1_next.count     = e.count;
        s1_next.area      = e.width * e.height;
        s1_next.version   = e.version;
        s1_next.format    = e.format;
        s1_next.flags     = e.flags;
        s1_next.width     = e.width;
        s1_next.height    = e.height;
        s1_next.depth     = e.depth;
        s1_next.mips      = mips;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        pix_done_next = pix_done_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
            pix_done_next = pix_phase && e.has_status;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pix_done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pix_done_reg <= pix_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= s1_next;
        end
    end

    // stage two: expected size and first failing check
    assign expect_bytes = 34'(thv_pkg::HEADER_BYTES)
                          + ({2'b00, s1_reg.area} * 34'(thv_pkg::PIX_BYTES));
    assign too_large    = s1_reg.n_big || (expect_bytes > {3'b000, cfg.max_member_bytes});
    assign layout_bad   = {2'b00, s1_reg.count} != expect_bytes;

    always_comb
    begin
        if (s1_reg.trunc)
        begin
            status_next = thv_pkg::ST_TRUNCATED;
        end
        else if (s1_reg.tag_bad)
        begin
            status_next = thv_pkg::ST_TAG;
        end
        else if (s1_reg.ver_bad)
        begin
            status_next = thv_pkg::ST_VERSION;
        end
        else if (s1_reg.fmt_bad)
        begin
            status_next = thv_pkg::ST_FORMAT;
        end
        else if (s1_reg.dims_bad)
        begin
            status_next = thv_pkg::ST_DIMS;
        end
        else if (s1_reg.size_bad)
        begin
            status_next = thv_pkg::ST_FILESIZE;
        end
        else if (!s1_reg.dec)
        begin
            status_next = thv_pkg::ST_OK;
        end
        else if (s1_reg.dfmt_bad)
        begin
            status_next = thv_pkg::ST_DEC_FORMAT;
        end
        else if (s1_reg.dflag_bad)
        begin
            status_next = thv_pkg::ST_DEC_FLAGS;
        end
        else if (s1_reg.ddim_bad)
        begin
            status_next = thv_pkg::ST_DEC_DIMS;
        end
        else if (too_large)
        begin
            status_next = thv_pkg::ST_TOO_LARGE;
        end
        else if (layout_bad)
        begin
            status_next = thv_pkg::ST_LAYOUT;
        end
        else
        begin
            status_next = thv_pkg::ST_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg    <= s1_reg.kind;
            pixel_reg   <= s1_reg.kind ? 32'd0 : s1_reg.pixel;
            status_reg  <= s1_reg.kind ? status_next : thv_pkg::ST_OK;
            if (s1_reg.kind && !s1_reg.trunc)
            begin
                version_reg <= s1_reg.version;
                format_reg  <= s1_reg.format;
                flags_reg   <= s1_reg.flags;
                width_reg   <= s1_reg.width;
                height_reg  <= s1_reg.height;
                depth_reg   <= s1_reg.depth;
                mips_reg    <= s1_reg.mips;
            end
            else
            begin
                version_reg <= 8'd0;
                format_reg  <= 8'd0;
                flags_reg   <= 8'd0;
                width_reg   <= 16'd0;
                height_reg  <= 16'd0;
                depth_reg   <= 16'd0;
                mips_reg    <= 5'd0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign pixel_rgba  = pixel_reg;
    assign status      = status_reg;
    assign version     = version_reg;
    assign format      = format_reg;
    assign flags       = flags_reg;
    assign width       = width_reg;
    assign height      = height_reg;
    assign depth       = depth_reg;
    assign mip_count   = mips_reg;
    assign last_result = kind_reg;

endmodule

// File: rtl/texture_header_validator.sv
// ============================================================================
// texture_header_validator
// Byte-stream texture header check with provisional RGBA pixel output.
// ============================================================================
// path: a result passes through the event queue, the stage-one register and the output register
// throughput: one byte per cycle while the queue has room; a last byte that also
//   completes a pixel yields a pixel result and then a status result, buffered by the two-entry queue
// reset: byte count, queue and pipeline valids cleared, registers to defaults;
//   header and pixel stores are not reset
module texture_header_validator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [thv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [thv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [31:0]                   pixel_rgba,
    output logic [3:0]                    status,
    output logic [7:0]                    version,
    output logic [7:0]                    format,
    output logic [7:0]                    flags,
    output logic [15:0]                   width,
    output logic [15:0]                   height,
    output logic [15:0]                   depth,
    output logic [4:0]                    mip_count,
    output logic                          last_result
);

    thv_pkg::thv_cfg_t   cfg_reg;
    thv_pkg::thv_cfg_t   cfg_next;
    thv_pkg::thv_entry_t push_entry;
    thv_pkg::thv_entry_t pop_entry;
    logic                push_valid;
    logic                push_ready;
    logic                pop_valid;
    logic                pop_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                thv_pkg::CFG_EXPECTED_VERSION: cfg_next.expected_version = cfg_data[7:0];
                thv_pkg::CFG_DECODE_MODE:      cfg_next.decode_mode      = cfg_data[0];
                thv_pkg::CFG_ARGB_FORMAT_CODE: cfg_next.argb_format_code = cfg_data[3:0];
                thv_pkg::CFG_MAX_MEMBER_BYTES: cfg_next.max_member_bytes = cfg_data[30:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= thv_pkg::RST_EXPECTED_VERSION;
            cfg_reg.decode_mode      <= thv_pkg::RST_DECODE_MODE;
            cfg_reg.argb_format_code <= thv_pkg::RST_ARGB_FORMAT_CODE;
            cfg_reg.max_member_bytes <= thv_pkg::RST_MAX_MEMBER_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    thv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    thv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    thv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .pixel_rgba  (pixel_rgba),
        .status      (status),
        .version     (version),
        .format      (format),
        .flags       (flags),
        .width       (width),
        .height      (height),
        .depth       (depth),
        .mip_count   (mip_count),
        .last_result (last_result)
    );

endmodule
